// ===== hdl/dbu_pkg.sv =====
// dbu_pkg: types, constants and helper functions of the double-byte to utf-8 transcoder
// used by every module under hdl/ but dbu_checker, depends on nothing

package dbu_pkg;

  // default table geometry
  localparam int LEAD_ROWS_DEF     = 130;
  localparam int TRAIL_COLUMNS_DEF = 190;

  // byte codes
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD_BASE   = 8'h81;
  localparam logic [7:0] TRAIL_BASE  = 8'h41;
  localparam logic [7:0] MID_DOT_B0  = 8'd194;
  localparam logic [7:0] MID_DOT_B1  = 8'd183;

  // most result bytes one transaction can cause
  localparam int MAX_BYTES = 3;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);

  // input mode codes
  localparam logic MODE_TEXT  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  typedef logic [CNT_W-1:0] dbu_cnt_t;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_BAD,
    KIND_LOOK
  } dbu_kind_t;

  // item handed from the decode stage to the emitter
  typedef struct packed {
    logic      valid;
    dbu_kind_t kind;
    logic [7:0] text;
  } dbu_item_t;

  // number of bytes to emit from one table entry
  function automatic dbu_cnt_t entry_count(input logic [23:0] entry);
    dbu_cnt_t n;
    if (entry[23:16] == 8'd0) begin
      n = dbu_cnt_t'(0);
    end else if (entry[15:8] == 8'd0) begin
      n = dbu_cnt_t'(1);
    end else if (entry[23:16] == MID_DOT_B0 && entry[15:8] == MID_DOT_B1) begin
      n = dbu_cnt_t'(2);
    end else if (entry[7:0] == 8'd0) begin
      n = dbu_cnt_t'(2);
    end else begin
      n = dbu_cnt_t'(MAX_BYTES);
    end
    return n;
  endfunction

endpackage

// ===== hdl/dbu_table.sv =====
// dbu_table: code table memory, one write port and one registered read port
// depends on dbu_pkg for the default depth

module dbu_table #(
  parameter int DEPTH = dbu_pkg::LEAD_ROWS_DEF * dbu_pkg::TRAIL_COLUMNS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [23:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [23:0]   rd_data
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/dbu_front.sv =====
// dbu_front: input decode, lead byte tracking, table addressing and the decode stage register
// depends on dbu_pkg

module dbu_front #(
  parameter int LEAD_ROWS     = dbu_pkg::LEAD_ROWS_DEF,
  parameter int TRAIL_COLUMNS = dbu_pkg::TRAIL_COLUMNS_DEF,
  parameter int AW            = (LEAD_ROWS * TRAIL_COLUMNS > 1) ?
                                $clog2(LEAD_ROWS * TRAIL_COLUMNS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_mode,
  input  logic [7:0]          in_byte_in,
  input  logic [7:0]          in_entry_row,
  input  logic [7:0]          in_entry_column,
  input  logic [23:0]         in_entry_value,
  input  logic                take,
  output dbu_pkg::dbu_item_t  item,
  output logic                wr_en,
  output logic [AW-1:0]       wr_addr,
  output logic [23:0]         wr_data,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr
);

  logic               lead_waiting_r, lead_waiting_nxt;
  logic [7:0]         held_lead_r, held_lead_nxt;
  dbu_pkg::dbu_item_t item_r, item_nxt;

  logic       accept, text_acc, res_acc, a_move;
  logic [7:0] row, col;
  logic       pair_bad;
  dbu_pkg::dbu_kind_t kind;

  assign a_move   = item_r.valid & take;
  assign in_stall = item_r.valid & ~take;
  assign accept   = in_valid & ~in_stall;
  assign text_acc = accept & (in_mode == dbu_pkg::MODE_TEXT);

  // pair geometry, offsets wrap below the bases and are caught by the compares
  assign row = held_lead_r - dbu_pkg::LEAD_BASE;
  assign col = in_byte_in - dbu_pkg::TRAIL_BASE;
  assign pair_bad = (held_lead_r < dbu_pkg::LEAD_BASE) || (in_byte_in < dbu_pkg::TRAIL_BASE) ||
                    ({1'b0, row} >= 9'(LEAD_ROWS)) || ({1'b0, col} >= 9'(TRAIL_COLUMNS));

  always_comb begin
    kind    = dbu_pkg::KIND_PASS;
    res_acc = 1'b0;
    if (lead_waiting_r) begin
      res_acc = text_acc;
      kind    = pair_bad ? dbu_pkg::KIND_BAD : dbu_pkg::KIND_LOOK;
    end else if (in_byte_in < dbu_pkg::ASCII_LIMIT) begin
      res_acc = text_acc;
    end
  end

  always_comb begin
    lead_waiting_nxt = lead_waiting_r;
    held_lead_nxt    = held_lead_r;
    if (text_acc) begin
      if (lead_waiting_r) begin
        lead_waiting_nxt = 1'b0;
      end else if (in_byte_in >= dbu_pkg::ASCII_LIMIT) begin
        lead_waiting_nxt = 1'b1;
        held_lead_nxt    = in_byte_in;
      end
    end
  end

  always_comb begin
    item_nxt = item_r;
    if (res_acc) begin
      item_nxt.valid = 1'b1;
      item_nxt.kind  = kind;
      item_nxt.text  = in_byte_in;
    end else if (a_move) begin
      item_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_waiting_r <= 1'b0;
      held_lead_r    <= 8'd0;
      item_r         <= '0;
    end else begin
      lead_waiting_r <= lead_waiting_nxt;
      held_lead_r    <= held_lead_nxt;
      item_r         <= item_nxt;
    end
  end

  assign item = item_r;

  assign wr_en   = accept && (in_mode == dbu_pkg::MODE_WRITE) &&
                   ({1'b0, in_entry_row} < 9'(LEAD_ROWS)) &&
                   ({1'b0, in_entry_column} < 9'(TRAIL_COLUMNS));
  assign wr_addr = AW'(in_entry_row) * AW'(TRAIL_COLUMNS) + AW'(in_entry_column);
  assign wr_data = in_entry_value;

  assign rd_en   = res_acc && (kind == dbu_pkg::KIND_LOOK);
  assign rd_addr = AW'(row) * AW'(TRAIL_COLUMNS) + AW'(col);

endmodule

// ===== hdl/dbu_emit.sv =====
// dbu_emit: result register, sends up to three bytes per transaction, one per unstalled cycle
// depends on dbu_pkg

module dbu_emit (
  input  logic               clk,
  input  logic               rst_n,
  input  dbu_pkg::dbu_item_t item,
  input  logic [23:0]        rd_data,
  output logic               take,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last_of_run,
  output logic               out_bad_code
);

  dbu_pkg::dbu_cnt_t cnt_r, cnt_nxt;
  logic [7:0]        b0_r, b0_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic              bad_r, bad_nxt;
  logic              sent, load;

  assign out_valid = (cnt_r != '0);
  assign sent      = out_valid & ~out_stall;
  // free now, or its last byte leaves this cycle
  assign take      = (cnt_r == '0) || (cnt_r == dbu_pkg::dbu_cnt_t'(1) && sent);
  assign load      = item.valid & take;

  always_comb begin
    cnt_nxt = cnt_r;
    b0_nxt  = b0_r;
    b1_nxt  = b1_r;
    b2_nxt  = b2_r;
    bad_nxt = bad_r;
    if (load) begin
      unique case (item.kind)
        dbu_pkg::KIND_PASS: begin
          cnt_nxt = dbu_pkg::dbu_cnt_t'(1);
          b0_nxt  = item.text;
          bad_nxt = 1'b0;
        end
        dbu_pkg::KIND_BAD: begin
          cnt_nxt = dbu_pkg::dbu_cnt_t'(1);
          b0_nxt  = 8'd0;
          bad_nxt = 1'b1;
        end
        dbu_pkg::KIND_LOOK: begin
          cnt_nxt = dbu_pkg::entry_count(rd_data);
          b0_nxt  = rd_data[23:16];
          b1_nxt  = rd_data[15:8];
          b2_nxt  = rd_data[7:0];
          bad_nxt = 1'b0;
        end
        default: begin
          cnt_nxt = '0;
        end
      endcase
    end else if (sent) begin
      cnt_nxt = cnt_r - dbu_pkg::dbu_cnt_t'(1);
      b0_nxt  = b1_r;
      b1_nxt  = b2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r  <= b0_nxt;
    b1_r  <= b1_nxt;
    b2_r  <= b2_nxt;
    bad_r <= bad_nxt;
  end

  assign out_byte        = b0_r;
  assign out_last_of_run = (cnt_r == dbu_pkg::dbu_cnt_t'(1));
  assign out_bad_code    = bad_r;

endmodule

// ===== hdl/double_byte_to_utf8_transcoder.sv =====
// double_byte_to_utf8_transcoder: top level, double-byte text to utf-8 through a loaded code table
// depends on dbu_pkg, dbu_front, dbu_table, dbu_emit
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_mode, in_byte_in, in_entry_row,
//                                           in_entry_column, in_entry_value
//   out      output     out_valid/out_stall out_byte, out_last_of_run, out_bad_code
//
// an input transaction is decoded and registered in the decode stage; a lookup reads the table
// in that same cycle, and the result register takes the entry once it is free to take it
// the result register sends one byte per cycle while out_stall is low: a pair gives up to three bytes,
// a single-byte character or a bad pair one, a lead byte or an empty entry none
// the table has no clearing pass: entries are valid only once written
// reset clears the lead tracking, the decode stage and the result count
// in_stall rises only while the decode stage is full and the result register is busy

module double_byte_to_utf8_transcoder #(
  parameter int LEAD_ROWS     = dbu_pkg::LEAD_ROWS_DEF,
  parameter int TRAIL_COLUMNS = dbu_pkg::TRAIL_COLUMNS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [7:0]  in_byte_in,
  input  logic [7:0]  in_entry_row,
  input  logic [7:0]  in_entry_column,
  input  logic [23:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_bad_code
);

  // table geometry follows the parameters
  localparam int DEPTH = LEAD_ROWS * TRAIL_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dbu_pkg::dbu_item_t item;
  logic               take;
  logic               wr_en, rd_en;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [23:0]        wr_data, rd_data;

  // decode, lead byte held between transactions, table addresses
  dbu_front #(
    .LEAD_ROWS     (LEAD_ROWS),
    .TRAIL_COLUMNS (TRAIL_COLUMNS),
    .AW            (AW)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_byte_in      (in_byte_in),
    .in_entry_row    (in_entry_row),
    .in_entry_column (in_entry_column),
    .in_entry_value  (in_entry_value),
    .take            (take),
    .item            (item),
    .wr_en           (wr_en),
    .wr_addr         (wr_addr),
    .wr_data         (wr_data),
    .rd_en           (rd_en),
    .rd_addr         (rd_addr)
  );

  // code table, read data lines up with the decode stage register
  dbu_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result register and byte sequencing
  dbu_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .item            (item),
    .rd_data         (rd_data),
    .take            (take),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_bad_code    (out_bad_code)
  );

endmodule

// ===== hdl/dbu_checker.sv =====
// dbu_checker: port-level assertions on the transcoder, bound to the top level
// depends on double_byte_to_utf8_transcoder

module dbu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_last_of_run,
  input logic       out_bad_code
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last_of_run) &&
    $stable(out_bad_code))
    else $error("stalled result changed");

  // a bad pair is a single zero byte that ends its run
  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_code |-> out_last_of_run && out_byte == 8'd0)
    else $error("bad code result malformed");

  // the rest of a run follows with no gap
  a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("gap inside a run");

  // input stalls only behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty result register");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind double_byte_to_utf8_transcoder dbu_checker u_dbu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run),
  .out_bad_code    (out_bad_code)
);

// ===== test/testbench.sv =====
// testbench: self-checking bench for double_byte_to_utf8_transcoder
// depends on dbu_pkg and the rtl under hdl/; keeps its own model of the code table and lead tracking
// directed tests first, then a random stream of table writes and text with bursty traffic

module testbench;

  localparam int ROWS    = dbu_pkg::LEAD_ROWS_DEF;
  localparam int COLS    = dbu_pkg::TRAIL_COLUMNS_DEF;
  localparam int ENTRIES = ROWS * COLS;

  // one output transaction as the bench expects it
  typedef struct packed {
    logic [7:0] text;
    logic       last;
    logic       bad;
  } utf8_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [7:0]  in_byte_in;
  logic [7:0]  in_entry_row;
  logic [7:0]  in_entry_column;
  logic [23:0] in_entry_value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic        out_bad_code;

  // bench copy of the block state
  logic         lead_pending;
  logic [7:0]   lead_code;
  logic [23:0]  code_mem [ENTRIES];
  // table indexes that a real lead/trail pair can reach (row 127 and up has no lead byte)
  int           readable_idx[$];
  utf8_result_t utf8_expected_q[$];

  int error_count;
  int accepted_items;
  int burst_left;

  double_byte_to_utf8_transcoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_byte_in      (in_byte_in),
    .in_entry_row    (in_entry_row),
    .in_entry_column (in_entry_column),
    .in_entry_value  (in_entry_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_bad_code    (out_bad_code)
  );

  // 4 time unit clock
  initial clk = 1'b0;
  always #2 clk = ~clk;

  // hard limit on run length, far beyond the slowest legal run
  initial begin
    #1000000;
    $display("testbench: errors");
    $finish;
  end

  // works out the utf-8 bytes that one accepted input transaction produces
  task automatic predict_utf8(input logic mode, input logic [7:0] text_byte,
                              input logic [7:0] row, input logic [7:0] col,
                              input logic [23:0] value);
    int           r;
    int           c;
    int           n;
    logic [23:0]  entry;
    logic [7:0]   bytes [3];
    utf8_result_t res;
    if (mode == dbu_pkg::MODE_WRITE) begin
      // writes outside the table geometry are dropped
      if (int'(row) < ROWS && int'(col) < COLS) begin
        code_mem[int'(row) * COLS + int'(col)] = value;
        if (int'(row) + int'(dbu_pkg::LEAD_BASE) <= 255) begin
          readable_idx.push_back(int'(row) * COLS + int'(col));
        end
      end
    end else if (!lead_pending) begin
      if (text_byte < dbu_pkg::ASCII_LIMIT) begin
        res.text = text_byte;
        res.last = 1'b1;
        res.bad  = 1'b0;
        utf8_expected_q.push_back(res);
      end else begin
        lead_pending = 1'b1;
        lead_code    = text_byte;
      end
    end else begin
      // trail byte: the lead is used up whatever happens
      lead_pending = 1'b0;
      r = int'(lead_code) - int'(dbu_pkg::LEAD_BASE);
      c = int'(text_byte) - int'(dbu_pkg::TRAIL_BASE);
      if (r < 0 || r >= ROWS || c < 0 || c >= COLS) begin
        res.text = 8'h00;
        res.last = 1'b1;
        res.bad  = 1'b1;
        utf8_expected_q.push_back(res);
      end else begin
        entry = code_mem[r * COLS + c];
        n = 0;
        if (entry[23:16] != 8'h00) begin
          bytes[0] = entry[23:16];
          n = 1;
          if (entry[15:8] != 8'h00) begin
            bytes[1] = entry[15:8];
            n = 2;
            // middle dot stops after two bytes even with a third byte present
            if (entry[7:0] != 8'h00 &&
                !(entry[23:16] == dbu_pkg::MID_DOT_B0 &&
                  entry[15:8] == dbu_pkg::MID_DOT_B1)) begin
              bytes[2] = entry[7:0];
              n = 3;
            end
          end
        end
        for (int k = 0; k < n; k++) begin
          res.text = bytes[k];
          res.last = (k == n - 1);
          res.bad  = 1'b0;
          utf8_expected_q.push_back(res);
        end
      end
    end
  endtask

  // one input transaction, with the sender idling between bursts
  task automatic drive_transaction(input logic mode, input logic [7:0] text_byte,
                                   input logic [7:0] row, input logic [7:0] col,
                                   input logic [23:0] value);
    int gap;
    if (burst_left == 0) begin
      // a quarter of the bursts follow straight on with no idle cycles
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk);
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_byte_in      <= text_byte;
    in_entry_row    <= row;
    in_entry_column <= col;
    in_entry_value  <= value;
    // hold the payload until the block takes it
    do @(posedge clk); while (in_stall);
    predict_utf8(mode, text_byte, row, col, value);
    accepted_items++;
  endtask

  // text transaction, unused table fields get random junk
  task automatic send_text(input logic [7:0] text_byte);
    drive_transaction(dbu_pkg::MODE_TEXT, text_byte, 8'($urandom), 8'($urandom),
                      24'($urandom));
  endtask

  // table write transaction, unused text byte gets random junk
  task automatic send_write(input logic [7:0] row, input logic [7:0] col,
                            input logic [23:0] value);
    drive_transaction(dbu_pkg::MODE_WRITE, 8'($urandom), row, col, value);
  endtask

  task automatic send_pair(input logic [7:0] lead, input logic [7:0] trail);
    send_text(lead);
    send_text(trail);
  endtask

  // stop sending until every expected byte has come out
  task automatic wait_for_drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (utf8_expected_q.size() != 0) @(posedge clk);
  endtask

  // table entry of a random shape: empty, one, two, middle dot, three bytes or raw
  function automatic logic [23:0] random_entry();
    logic [23:0] v;
    case ($urandom_range(0, 5))
      0: v = {8'h00, 16'($urandom)};
      1: v = {8'($urandom_range(1, 255)), 8'h00, 8'($urandom)};
      2: v = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 8'h00};
      3: v = {dbu_pkg::MID_DOT_B0, dbu_pkg::MID_DOT_B1, 8'($urandom)};
      4: v = {8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
              8'($urandom_range(1, 255))};
      default: v = 24'($urandom);
    endcase
    return v;
  endfunction

  // lead and trail that address a written, reachable entry
  task automatic pick_written_pair(output logic [7:0] lead, output logic [7:0] trail);
    int idx;
    idx   = readable_idx[$urandom_range(0, readable_idx.size() - 1)];
    lead  = 8'(int'(dbu_pkg::LEAD_BASE) + idx / COLS);
    trail = 8'(int'(dbu_pkg::TRAIL_BASE) + idx % COLS);
  endtask

  // compare each accepted output transaction with the oldest expectation
  task automatic check_result;
    utf8_result_t want;
    if (utf8_expected_q.size() == 0) begin
      error_count++;
      if (error_count <= 10) begin
        $display("unexpected output: byte %h last %b bad %b",
                 out_byte, out_last_of_run, out_bad_code);
      end
    end else begin
      want = utf8_expected_q.pop_front();
      if (out_byte !== want.text || out_last_of_run !== want.last ||
          out_bad_code !== want.bad) begin
        error_count++;
        if (error_count <= 10) begin
          $display("mismatch: expected byte %h last %b bad %b, got byte %h last %b bad %b",
                   want.text, want.last, want.bad, out_byte, out_last_of_run, out_bad_code);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      check_result();
    end
  end

  // receiver back-pressure: switches among free running, light, heavy or periodic stalls
  initial begin
    int level;
    int cyc;
    out_stall = 1'b0;
    level = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (cyc % 48 == 0) begin
        level = $urandom_range(0, 3);
      end
      cyc++;
      case (level)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 9) < 6);
        default: out_stall <= ((cyc % 11) < 7);
      endcase
    end
  end

  // ascii extremes pass straight through
  task automatic test_ascii_passthrough;
    send_text(8'h00);
    send_text(8'h7F);
  endtask

  // every entry shape, the corners of the table and a write outside it
  task automatic test_table_lookup;
    send_write(8'd0, 8'd0, 24'hE4B880);          // three bytes, first row and column
    send_write(8'd126, 8'd189, 24'hC3A900);      // two bytes, last reachable corner
    send_write(8'd5, 8'd10, {dbu_pkg::MID_DOT_B0, dbu_pkg::MID_DOT_B1, 8'h41});
    send_write(8'd5, 8'd11, 24'h41005A);         // one byte, third byte ignored
    send_write(8'd7, 8'd20, 24'h00FFFF);         // empty entry, no output
    send_write(8'd130, 8'd190, 24'hFFFFFF);      // off the table, dropped
    send_pair(8'h81, 8'h41);
    send_pair(8'hFF, 8'hFE);
    send_pair(8'h86, 8'h4B);
    send_pair(8'h86, 8'h4C);
    send_pair(8'h88, 8'h55);
  endtask

  // pairs outside the table give one flagged byte and consume the lead
  task automatic test_out_of_table_pairs;
    send_pair(8'h80, 8'h85);                     // lead below the table, trail not a new lead
    send_pair(8'h81, 8'h40);                     // trail just below the table
    send_pair(8'hC0, 8'hFF);                     // trail past the last column
  endtask

  // lead held across an idle drain and a table write, then completed
  task automatic test_lead_held;
    send_text(8'hFF);
    wait_for_drain();
    send_write(8'd126, 8'd189, 24'hEFBFBD);
    send_text(8'hFE);
  endtask

  // mostly well-formed traffic with random content, some writes and broken pairs
  task automatic test_random_stream;
    int          start;
    int          pick;
    logic [7:0]  lead;
    logic [7:0]  trail;
    logic [7:0]  row;
    logic [7:0]  col;
    start = accepted_items;
    while (accepted_items - start < 225) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        send_text(8'($urandom_range(0, 127)));
      end else if (pick < 65) begin
        pick_written_pair(lead, trail);
        send_pair(lead, trail);
      end else if (pick < 80) begin
        // mostly reachable rows, a few unreachable rows and some writes off the table
        case ($urandom_range(0, 19))
          0, 1:    row = 8'($urandom);
          2:       row = 8'($urandom_range(127, 129));
          default: row = 8'($urandom_range(0, 126));
        endcase
        col = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, COLS - 1));
        send_write(row, col, random_entry());
      end else if (pick < 92) begin
        case ($urandom_range(0, 2))
          0:       send_pair(8'h80, 8'($urandom));
          1:       send_pair(8'($urandom_range(128, 255)), 8'($urandom_range(0, 64)));
          default: send_pair(8'($urandom_range(128, 255)), 8'hFF);
        endcase
      end else begin
        // table write lands between lead and trail
        pick_written_pair(lead, trail);
        send_text(lead);
        send_write(8'($urandom_range(0, 126)), 8'($urandom_range(0, COLS - 1)),
                   random_entry());
        send_text(trail);
      end
    end
  endtask

  initial begin
    // every input known from time zero
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_mode         = dbu_pkg::MODE_TEXT;
    in_byte_in      = 8'h00;
    in_entry_row    = 8'h00;
    in_entry_column = 8'h00;
    in_entry_value  = 24'h000000;
    lead_pending    = 1'b0;
    lead_code       = 8'h00;
    error_count     = 0;
    accepted_items  = 0;
    burst_left      = 0;

    // synchronous reset held at the start, then released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_ascii_passthrough();
    test_table_lookup();
    test_out_of_table_pairs();
    test_lead_held();
    test_random_stream();

    // let the last bytes out, then wait on to catch anything extra
    wait_for_drain();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
